### sv/cdate_pkg.sv
`timescale 1ns / 1ps
// Types, constants and the microcode ROM shared by the calendar date counter.
// No dependencies; used by cdate_seq, cdate_dp and calendar_date_counter_unit.
package cdate_pkg;

  // Field widths fixed by the interface
  localparam int MONTH_IN_W = 4;
  localparam int DAY_IN_W   = 6;
  localparam int YEAR_W     = 12;
  localparam int CNT_IN_W   = 16;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;

  // Microprogram counter width (five-step program in an eight-word ROM)
  localparam int UPC_W = 3;

  // Calendar limits
  localparam logic [YEAR_W-1:0]  YEAR_MIN     = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_MAX_SET = 12'd2100;
  localparam logic [YEAR_W-1:0]  YEAR_LIMIT   = 12'd4095;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;
  localparam logic [6:0]         YR_LO_LAST   = 7'd99;
  localparam logic [5:0]         CEN_MIN      = 6'd19;

  // Request types
  localparam logic REQ_SET     = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_SET,
    OP_ADVANCE,
    OP_EMIT
  } op_t;

  // Branch conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_REQ_ADV,
    COND_ADV_DONE,
    COND_OUT_FREE
  } cond_t;

  // One control word: if cond holds jump to target, else hold or step on
  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             hold;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic in_take;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic req_adv;
    logic adv_done;
    logic out_free;
  } status_t;

  // Program step addresses
  localparam logic [UPC_W-1:0] UA_WAIT    = 3'd0;
  localparam logic [UPC_W-1:0] UA_BRANCH  = 3'd1;
  localparam logic [UPC_W-1:0] UA_SET     = 3'd2;
  localparam logic [UPC_W-1:0] UA_ADVANCE = 3'd3;
  localparam logic [UPC_W-1:0] UA_EMIT    = 3'd4;

  // Microcode ROM
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: UA_WAIT};
    unique case (addr)
      // wait for a transaction and capture it
      UA_WAIT:    w = '{op: OP_LATCH,   cond: COND_IN_VALID, hold: 1'b1, target: UA_BRANCH};
      // advance requests go to the day loop, set falls through
      UA_BRANCH:  w = '{op: OP_NOP,     cond: COND_REQ_ADV,  hold: 1'b0, target: UA_ADVANCE};
      UA_SET:     w = '{op: OP_SET,     cond: COND_ALWAYS,   hold: 1'b0, target: UA_EMIT};
      // one day per pass until the count runs out or the date saturates
      UA_ADVANCE: w = '{op: OP_ADVANCE, cond: COND_ADV_DONE, hold: 1'b1, target: UA_EMIT};
      // hand the date to the output register
      UA_EMIT:    w = '{op: OP_EMIT,    cond: COND_OUT_FREE, hold: 1'b1, target: UA_WAIT};
      default:    w = '{op: OP_NOP,     cond: COND_ALWAYS,   hold: 1'b0, target: UA_WAIT};
    endcase
    return w;
  endfunction

  // Gregorian month length; invalid month codes read as 31
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Leap rule from year split as century and year within century
  function automatic logic leap_of(input logic [6:0] lo, input logic [5:0] cen);
    return (lo != 7'd0) ? (lo[1:0] == 2'd0) : (cen[1:0] == 2'd0);
  endfunction

endpackage

### sv/cdate_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on cdate_pkg.
module cdate_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cdate_pkg::status_t status,
  output cdate_pkg::ctrl_t  ctrl,
  output logic              in_stall
);

  logic [cdate_pkg::UPC_W-1:0] upc;
  logic [cdate_pkg::UPC_W-1:0] upc_next;
  cdate_pkg::uword_t           uw;
  logic                        cond_ok;

  // Control word for the current step
  assign uw = cdate_pkg::ucode(upc);

  // Branch condition select
  always_comb begin
    unique case (uw.cond)
      cdate_pkg::COND_ALWAYS:   cond_ok = 1'b1;
      cdate_pkg::COND_IN_VALID: cond_ok = in_valid;
      cdate_pkg::COND_REQ_ADV:  cond_ok = status.req_adv;
      cdate_pkg::COND_ADV_DONE: cond_ok = status.adv_done;
      cdate_pkg::COND_OUT_FREE: cond_ok = status.out_free;
      default:                  cond_ok = 1'b1;
    endcase
  end

  // Next step: jump, hold, or fall through
  always_comb begin
    if (cond_ok) begin
      upc_next = uw.target;
    end else if (uw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + cdate_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= cdate_pkg::UA_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

  // Input is taken only in the capture step
  assign in_stall     = (uw.op != cdate_pkg::OP_LATCH);
  assign ctrl.op      = uw.op;
  assign ctrl.in_take = (uw.op == cdate_pkg::OP_LATCH) && in_valid;

endmodule

### sv/cdate_dp.sv
`timescale 1ns / 1ps
// Date datapath: input capture, set validation, one-day step, output register.
// Depends on cdate_pkg; driven by cdate_seq control words.
module cdate_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cdate_pkg::ctrl_t                ctrl,
  output cdate_pkg::status_t              status,
  input  logic                            req_type,
  input  logic [cdate_pkg::MONTH_IN_W-1:0] month_in,
  input  logic [cdate_pkg::DAY_IN_W-1:0]  day_in,
  input  logic [cdate_pkg::YEAR_W-1:0]    year_in,
  input  logic [cdate_pkg::CNT_IN_W-1:0]  day_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cdate_pkg::MONTH_W-1:0]   month_out,
  output logic [cdate_pkg::DAY_W-1:0]     day_out,
  output logic [cdate_pkg::YEAR_W-1:0]    year_out,
  output logic                            overflow
);

  // Only the low COUNT_WIDTH bits of the count field take part
  localparam int CntW = (COUNT_WIDTH < cdate_pkg::CNT_IN_W) ? COUNT_WIDTH
                                                            : cdate_pkg::CNT_IN_W;

  // Captured transaction
  logic                             req_q;
  logic [cdate_pkg::MONTH_IN_W-1:0] mon_q;
  logic [cdate_pkg::DAY_IN_W-1:0]   day_q;
  logic [cdate_pkg::YEAR_W-1:0]     yr_q;
  logic [CntW-1:0]                  cnt;

  // Current date, with the year also kept as century and year within century
  logic [cdate_pkg::MONTH_W-1:0] cur_month;
  logic [cdate_pkg::DAY_W-1:0]   cur_day;
  logic [cdate_pkg::YEAR_W-1:0]  cur_year;
  logic [6:0]                    yr_lo;
  logic [5:0]                    yr_cen;
  logic                          ovf;

  // Set path
  logic [cdate_pkg::MONTH_W-1:0] set_month;
  logic [cdate_pkg::YEAR_W-1:0]  set_year;
  logic [cdate_pkg::YEAR_W-1:0]  set_off_full;
  logic [7:0]                    set_off;
  logic [6:0]                    set_lo;
  logic [5:0]                    set_cen;
  logic [cdate_pkg::DAY_W-1:0]   set_len;
  logic [cdate_pkg::DAY_W-1:0]   set_day;

  // Advance path
  logic [cdate_pkg::DAY_W-1:0]   cur_len;
  logic                          at_end;
  logic                          at_limit;
  logic                          cnt_zero;
  logic                          out_free;

  // Validate a set request
  always_comb begin
    set_month = ((mon_q >= cdate_pkg::MONTH_JAN) && (mon_q <= cdate_pkg::MONTH_DEC))
                ? mon_q : cdate_pkg::MONTH_JAN;
    set_year  = ((yr_q >= cdate_pkg::YEAR_MIN) && (yr_q <= cdate_pkg::YEAR_MAX_SET))
                ? yr_q : cdate_pkg::YEAR_MIN;
    set_off_full = set_year - cdate_pkg::YEAR_MIN;
    set_off      = set_off_full[7:0];
    if (set_off < 8'd100) begin
      set_lo  = set_off[6:0];
      set_cen = 6'd19;
    end else if (set_off < 8'd200) begin
      set_lo  = 7'(set_off - 8'd100);
      set_cen = 6'd20;
    end else begin
      set_lo  = 7'd0;
      set_cen = 6'd21;
    end
    set_len = cdate_pkg::month_days(set_month, cdate_pkg::leap_of(set_lo, set_cen));
    set_day = ((day_q >= 6'd1) && (day_q <= {1'b0, set_len})) ? day_q[4:0]
                                                              : cdate_pkg::DAY_FIRST;
  end

  // Month end and saturation detection for the day loop
  always_comb begin
    cur_len  = cdate_pkg::month_days(cur_month, cdate_pkg::leap_of(yr_lo, yr_cen));
    at_end   = (cur_day >= cur_len);
    at_limit = at_end && (cur_month == cdate_pkg::MONTH_DEC) &&
               (cur_year >= cdate_pkg::YEAR_LIMIT);
    cnt_zero = (cnt == '0);
    out_free = !out_valid || !out_stall;
  end

  assign status.req_adv  = (req_q == cdate_pkg::REQ_ADVANCE);
  assign status.adv_done = cnt_zero || at_limit;
  assign status.out_free = out_free;

  // Date state and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_month <= cdate_pkg::MONTH_JAN;
      cur_day   <= cdate_pkg::DAY_FIRST;
      cur_year  <= cdate_pkg::YEAR_MIN;
      yr_lo     <= 7'd0;
      yr_cen    <= cdate_pkg::CEN_MIN;
      ovf       <= 1'b0;
    end else begin
      unique case (ctrl.op)
        cdate_pkg::OP_LATCH: begin
          if (ctrl.in_take) begin
            ovf <= 1'b0;
          end
        end
        cdate_pkg::OP_SET: begin
          cur_month <= set_month;
          cur_day   <= set_day;
          cur_year  <= set_year;
          yr_lo     <= set_lo;
          yr_cen    <= set_cen;
        end
        cdate_pkg::OP_ADVANCE: begin
          if (!cnt_zero) begin
            if (at_limit) begin
              cur_day  <= cdate_pkg::DAY_LAST_DEC;
              cur_year <= cdate_pkg::YEAR_LIMIT;
              ovf      <= 1'b1;
            end else if (!at_end) begin
              cur_day <= cur_day + cdate_pkg::DAY_W'(1);
            end else begin
              cur_day <= cdate_pkg::DAY_FIRST;
              if (cur_month == cdate_pkg::MONTH_DEC) begin
                cur_month <= cdate_pkg::MONTH_JAN;
                cur_year  <= cur_year + cdate_pkg::YEAR_W'(1);
                if (yr_lo == cdate_pkg::YR_LO_LAST) begin
                  yr_lo  <= 7'd0;
                  yr_cen <= yr_cen + 6'd1;
                end else begin
                  yr_lo <= yr_lo + 7'd1;
                end
              end else begin
                cur_month <= cur_month + cdate_pkg::MONTH_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Transaction capture and day countdown
  always_ff @(posedge clk) begin
    if (ctrl.in_take) begin
      req_q <= req_type;
      mon_q <= month_in;
      day_q <= day_in;
      yr_q  <= year_in;
      cnt   <= day_count[CntW-1:0];
    end else if ((ctrl.op == cdate_pkg::OP_ADVANCE) && !cnt_zero && !at_limit) begin
      cnt <= cnt - CntW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.op == cdate_pkg::OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == cdate_pkg::OP_EMIT) && out_free) begin
      month_out <= cur_month;
      day_out   <= cur_day;
      year_out  <= cur_year;
      overflow  <= ovf;
    end
  end

endmodule

### sv/calendar_date_counter_unit.sv
`timescale 1ns / 1ps
// Calendar date counter top level: microcode sequencer plus date datapath.
// A set transaction passes the branch, set and emit steps before its result
// is registered; an advance passes branch, the day loop (one day per cycle)
// and emit. A new transaction is taken only once the last result is emitted.
// Reset (synchronous): date is 1 Jan 1900, no result pending, input taken next.
// Depends on cdate_pkg, cdate_seq, cdate_dp.
module calendar_date_counter_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [cdate_pkg::MONTH_IN_W-1:0] month_in,
  input  logic [cdate_pkg::DAY_IN_W-1:0]   day_in,
  input  logic [cdate_pkg::YEAR_W-1:0]     year_in,
  input  logic [cdate_pkg::CNT_IN_W-1:0]   day_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cdate_pkg::MONTH_W-1:0]    month_out,
  output logic [cdate_pkg::DAY_W-1:0]      day_out,
  output logic [cdate_pkg::YEAR_W-1:0]     year_out,
  output logic                             overflow
);

  cdate_pkg::ctrl_t   ctrl;
  cdate_pkg::status_t status;

  // Control program
  cdate_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // Date datapath and output register
  cdate_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .req_type  (req_type),
    .month_in  (month_in),
    .day_in    (day_in),
    .year_in   (year_in),
    .day_count (day_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .month_out (month_out),
    .day_out   (day_out),
    .year_out  (year_out),
    .overflow  (overflow)
  );

endmodule
